### hw/rtl/dscc_pkg.sv
// Package for the descriptor stream CRC checker: beat types, status and
// register index codes, controller/datapath interface structs and the CRC step.
// No dependencies.
package dscc_pkg;

  // Reflected CRC-16-CCITT polynomial and start value.
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Reset value of the image size limit register.
  localparam logic [15:0] MAX_IMAGE_RESET = 16'd16384;

  // Header is four bytes: length low, length high, code low, code high.
  localparam logic [15:0] HDR_BYTES = 16'd4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_CODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IMAGE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_TAINTED = 2'd2;
  localparam int CFG_DATA_W = 16;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DUPLICATE   = 3'd1;
  localparam logic [2:0] ST_BAD_CRC     = 3'd2;
  localparam logic [2:0] ST_BAD_FRAMING = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  entry_count;
    logic [15:0] payload_bytes;
    logic        tainted;
    logic [15:0] computed_crc;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;          // an input beat is accepted this cycle
    logic       end_rec;       // header was the end record: move to trailer
    logic       start_search;  // begin the duplicate code search
    logic       step_search;   // advance the duplicate code search by one step
    logic       commit;        // store the code and update the totals
    logic       set_tainted;   // record an accepted fault
    logic       emit;          // close the image with emit_status
    logic [2:0] emit_status;
    logic       load_out;      // move the pending result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic take_emits;   // the offered beat closes the image at the trailer
    logic take_hdr;     // the offered beat completes a record header
    logic is_end;       // stored header code equals the end code
    logic bad_len;      // stored length word is out of range
    logic search_done;
    logic dup;
    logic allow;
    logic table_full;
    logic out_free;     // output register can take a result this cycle
  } stat_t;

  // One byte step of the reflected CRC.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/dscc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dscc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/dscc_datapath.sv
// Datapath of the descriptor stream CRC checker: parse registers, CRC,
// configuration registers, code table search and the result register.
// Depends on dscc_pkg and dscc_ram.
module dscc_datapath #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dscc_pkg::in_beat_t                  byte_data,
  input  logic                                cfg_we,
  input  logic [dscc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dscc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  dscc_pkg::cmd_t                      cmd,
  output dscc_pkg::stat_t                     stat,
  output logic                                result_valid,
  input  logic                                result_stall,
  output dscc_pkg::out_beat_t                 result_data
);
  import dscc_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam logic [UW-1:0] TABLE_DEPTH = UW'(MAX_ENTRIES);

  // Configuration registers.
  logic [15:0] end_code;
  logic [15:0] max_image_bytes;
  logic        allow_tainted;

  // Parse state.
  logic [15:0] running_crc;
  logic [15:0] byte_in_record;
  logic [15:0] length_word;
  logic [15:0] record_code;
  logic [7:0]  stored_crc_low;
  logic [8:0]  accepted_entries;
  logic [15:0] byte_total;
  logic        tainted_flag;
  logic        finished;
  logic        at_trailer;
  logic [UW-1:0] table_used;

  // Search state.
  logic [UW-1:0] issue_idx;
  logic          rd_pending;
  logic          dup_found;
  logic [15:0]   rd_code;

  // Pending result.
  logic [2:0]  pend_status;
  logic [15:0] pend_crc;

  // State as seen by the offered beat, after an optional start-of-image clear.
  logic        sof;
  logic [15:0] eff_crc;
  logic [15:0] eff_bir;
  logic        eff_finished;
  logic        eff_trailer;
  logic [7:0]  eff_crc_low;
  logic [15:0] eff_length;
  logic [15:0] eff_code;
  logic [15:0] crc_stepped;
  logic [15:0] rx_crc;
  logic        crc_mismatch;
  logic [16:0] rec_size;
  logic [16:0] bir_inc;
  logic [17:0] total_sum;

  always_comb begin
    sof          = byte_data.start_of_image;
    eff_crc      = sof ? CRC_INIT : running_crc;
    eff_bir      = sof ? 16'd0 : byte_in_record;
    eff_finished = sof ? 1'b0 : finished;
    eff_trailer  = sof ? 1'b0 : at_trailer;
    eff_crc_low  = sof ? 8'd0 : stored_crc_low;
    eff_length   = sof ? 16'd0 : length_word;
    eff_code     = sof ? 16'd0 : record_code;
    crc_stepped  = crc16_byte(eff_crc, byte_data.data_byte);
    rx_crc       = {byte_data.data_byte, eff_crc_low};
    crc_mismatch = (rx_crc != eff_crc);
    rec_size     = ({1'b0, length_word} + 17'd1) << 1;
    bir_inc      = {1'b0, eff_bir} + 17'd1;
    total_sum    = {2'b00, byte_total} + {1'b0, rec_size};
  end

  // Status toward the controller.
  always_comb begin
    stat.take_emits  = !eff_finished && eff_trailer && (eff_bir != 16'd0);
    stat.take_hdr    = !eff_finished && !eff_trailer && (eff_bir == 16'd3);
    stat.is_end      = (record_code == end_code);
    stat.bad_len     = (length_word < 16'd2) ||
                       (length_word >= {1'b0, max_image_bytes[15:1]});
    stat.search_done = (issue_idx == table_used) && !rd_pending;
    stat.dup         = dup_found;
    stat.allow       = allow_tainted;
    stat.table_full  = (table_used == TABLE_DEPTH);
    stat.out_free    = !result_valid || !result_stall;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_code        <= 16'd0;
      max_image_bytes <= MAX_IMAGE_RESET;
      allow_tainted   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_END_CODE:      end_code        <= cfg_data;
        CFG_MAX_IMAGE:     max_image_bytes <= cfg_data;
        CFG_ALLOW_TAINTED: allow_tainted   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Parse, search and commit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc      <= CRC_INIT;
      byte_in_record   <= 16'd0;
      length_word      <= 16'd0;
      record_code      <= 16'd0;
      stored_crc_low   <= 8'd0;
      accepted_entries <= 9'd0;
      byte_total       <= 16'd0;
      tainted_flag     <= 1'b0;
      finished         <= 1'b0;
      at_trailer       <= 1'b0;
      table_used       <= '0;
      issue_idx        <= '0;
      rd_pending       <= 1'b0;
      dup_found        <= 1'b0;
    end else begin
      if (cmd.take) begin
        // Start of image clears the parse state and table fill count before the byte is parsed.
        if (sof) begin
          running_crc      <= CRC_INIT;
          byte_in_record   <= 16'd0;
          length_word      <= 16'd0;
          record_code      <= 16'd0;
          stored_crc_low   <= 8'd0;
          accepted_entries <= 9'd0;
          byte_total       <= 16'd0;
          tainted_flag     <= 1'b0;
          finished         <= 1'b0;
          at_trailer       <= 1'b0;
          table_used       <= '0;
        end
        if (!eff_finished) begin
          if (eff_trailer) begin
            // Trailer: low CRC byte, then the compare that closes the image.
            if (eff_bir == 16'd0) begin
              stored_crc_low <= byte_data.data_byte;
              byte_in_record <= 16'd1;
            end else begin
              finished <= 1'b1;
              pend_crc <= eff_crc;
              if (crc_mismatch && !allow_tainted) begin
                pend_status <= ST_BAD_CRC;
              end else begin
                pend_status <= ST_OK;
              end
              if (crc_mismatch && allow_tainted) begin
                tainted_flag <= 1'b1;
              end
            end
          end else begin
            running_crc <= crc_stepped;
            if (eff_bir >= HDR_BYTES) begin
              // Record body: count bytes up to the record's real size.
              if (bir_inc >= rec_size) begin
                byte_in_record <= 16'd0;
              end else begin
                byte_in_record <= bir_inc[15:0];
              end
            end else begin
              // Header bytes, little endian.
              unique case (eff_bir[1:0])
                2'd0: length_word <= {8'h00, byte_data.data_byte};
                2'd1: length_word <= {byte_data.data_byte, eff_length[7:0]};
                2'd2: record_code <= {8'h00, byte_data.data_byte};
                default: record_code <= {byte_data.data_byte, eff_code[7:0]};
              endcase
              byte_in_record <= bir_inc[15:0];
            end
          end
        end
      end

      // End record: invert the CRC and wait for the two trailer bytes.
      if (cmd.end_rec) begin
        running_crc    <= ~running_crc;
        at_trailer     <= 1'b1;
        byte_in_record <= 16'd0;
      end

      // Duplicate search, one table entry per cycle.
      if (cmd.start_search) begin
        issue_idx  <= '0;
        rd_pending <= 1'b0;
        dup_found  <= 1'b0;
      end
      if (cmd.step_search) begin
        if (issue_idx != table_used) begin
          issue_idx  <= issue_idx + 1'b1;
          rd_pending <= 1'b1;
        end else begin
          rd_pending <= 1'b0;
        end
        if (rd_pending && (rd_code == record_code)) begin
          dup_found <= 1'b1;
        end
      end

      if (cmd.set_tainted) begin
        tainted_flag <= 1'b1;
      end

      // Accept the record: store its code and update the saturating totals.
      if (cmd.commit) begin
        table_used <= table_used + 1'b1;
        if (accepted_entries != 9'h1FF) begin
          accepted_entries <= accepted_entries + 9'd1;
        end
        byte_total <= (total_sum > 18'h0FFFF) ? 16'hFFFF : total_sum[15:0];
      end

      if (cmd.emit) begin
        finished    <= 1'b1;
        pend_status <= cmd.emit_status;
        pend_crc    <= 16'd0;
      end
    end
  end

  // Code table.
  dscc_ram #(
    .WIDTH(16),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (table_used[AW-1:0]),
    .wdata (record_code),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_code)
  );

  // Output register: holds a result until the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_data.status        <= pend_status;
      result_data.entry_count   <= accepted_entries;
      result_data.payload_bytes <= byte_total;
      result_data.tainted       <= tainted_flag;
      result_data.computed_crc  <= pend_crc;
    end
  end

endmodule

### hw/rtl/dscc_ctrl.sv
// Controller of the descriptor stream CRC checker: sequences byte intake,
// header decisions, the duplicate search and result hand-off.
// Depends on dscc_pkg.
module dscc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  dscc_pkg::stat_t stat,
  output dscc_pkg::cmd_t  cmd
);
  import dscc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (byte_valid) begin
          cmd.take = 1'b1;
          priority if (stat.take_emits) begin
            state_next = S_EMIT;
          end else if (stat.take_hdr) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DECIDE: begin
        priority if (stat.is_end) begin
          cmd.end_rec = 1'b1;
          state_next  = S_IDLE;
        end else if (stat.bad_len) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BAD_FRAMING;
          state_next      = S_EMIT;
        end else begin
          cmd.start_search = 1'b1;
          state_next       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step_search = 1'b1;
        if (stat.search_done) begin
          cmd.set_tainted = stat.dup && stat.allow;
          priority if (stat.dup && !stat.allow) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_DUPLICATE;
            state_next      = S_EMIT;
          end else if (stat.table_full) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_TABLE_FULL;
            state_next      = S_EMIT;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_stall <= 1'b0;
    end else begin
      state      <= state_next;
      byte_stall <= (state_next != S_IDLE);
    end
  end

endmodule

### hw/rtl/descriptor_stream_crc_checker.sv
// Top level of the descriptor stream CRC checker.
// Depends on dscc_pkg, dscc_ctrl and dscc_datapath.
//
// Usage:
//   Input channel byte_*: one image byte per beat; start_of_image set on a
//   beat clears all parse state before that byte is taken.
//   Result channel result_*: one beat per image, when the end record's CRC
//   has been checked or at the first error. Later bytes are ignored until
//   the next start_of_image. cfg_we with cfg_index/cfg_data writes end_code
//   (0), max_image_bytes (1) or allow_tainted (2). The user must write
//   only while idle; the block itself does not enforce this.
// Sequence:
//   Body, trailer and the first three header bytes are taken in S_IDLE.
//   The fourth header byte leads to S_DECIDE and then to the duplicate
//   search in S_SEARCH. After the closing byte, a failing decision or the
//   search, S_EMIT moves the result into the output register once free.
// Reset and stall:
//   Synchronous reset clears parse state, table fill count and registers;
//   the table RAM needs no clearing. The output register holds a result
//   while result_stall is high; intake continues and only a further result
//   waits for the register to empty.
module descriptor_stream_crc_checker #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  dscc_pkg::in_beat_t                byte_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output dscc_pkg::out_beat_t               result_data,
  input  logic                              cfg_we,
  input  logic [dscc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dscc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dscc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  dscc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Parse registers, code table and output register.
  dscc_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .byte_data    (byte_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
